@@ sv/awb_otp_gain_calc_core_assert.svh @@
// ----------------------------------------------------------------------------
// AWB gain calc assertion macros
// Concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AWB_OTP_GAIN_CALC_CORE_ASSERT_SVH
`define AWB_OTP_GAIN_CALC_CORE_ASSERT_SVH
`ifndef SYNTH
`define AWB_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("assertion failed: condition must never hold");
`define AWB_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication violated");
`else
`define AWB_ASSERT_NEVER(lbl, cond)
`define AWB_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

@@ sv/awbgc_pkg.sv @@
// ----------------------------------------------------------------------------
// AWB gain calc package
// Widths, depths, register indexes and shared types.
// ----------------------------------------------------------------------------
package awbgc_pkg;

	localparam int DIV_W    = 44;
	localparam int DEN_W    = 18;
	localparam int DIV_STEP = 4;
	localparam int DIV_LAT  = DIV_W / DIV_STEP;
	localparam int RATIO_W  = 18;
	localparam int GG_W     = 26;
	localparam int GAIN_W   = 16;
	localparam int CFG_W    = 16;

	localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'h0100;
	localparam logic [GAIN_W-1:0] GAIN_MAX   = 16'hFFFF;
	localparam logic [CFG_W-1:0]  RG_TYP_RST = 16'h0331;
	localparam logic [CFG_W-1:0]  BG_TYP_RST = 16'h028A;

	localparam logic CFG_RG_TYP = 1'b0;
	localparam logic CFG_BG_TYP = 1'b1;

	localparam logic [1:0] CH_NONE = 2'd0;
	localparam logic [1:0] CH_RED  = 2'd1;
	localparam logic [1:0] CH_BLUE = 2'd2;

	localparam int MIDQ_DEPTH = 16;
	localparam int MIDQ_AW    = 4;
	localparam int MIDQ_CW    = 5;
	localparam int OUTQ_DEPTH = 32;
	localparam int OUTQ_AW    = 5;
	localparam int OUTQ_CW    = 6;

	typedef struct packed {
		logic [CFG_W-1:0] rgt;
		logic [CFG_W-1:0] bgt;
	} cfg_t;

	typedef struct packed {
		logic [RATIO_W-1:0] rg;
		logic [RATIO_W-1:0] bg;
		logic               green_zero;
		logic               bg_lt;
		logic               rg_lt;
	} cls_t;

	typedef struct packed {
		logic [GAIN_W-1:0] red;
		logic [GAIN_W-1:0] green;
		logic [GAIN_W-1:0] blue;
		logic              fault;
	} res_t;

endpackage

@@ sv/awbgc_div.sv @@
// ----------------------------------------------------------------------------
// AWB gain calc divider
// Pipelined restoring divider, four quotient bits per stage.
// ----------------------------------------------------------------------------
module awbgc_div (
	input  logic                          clk,
	input  logic [awbgc_pkg::DIV_W-1:0]   dividend,
	input  logic [awbgc_pkg::DEN_W-1:0]   divisor,
	output logic [awbgc_pkg::DIV_W-1:0]   quotient
);

	logic [awbgc_pkg::DIV_W-1:0] num_q [awbgc_pkg::DIV_LAT];
	logic [awbgc_pkg::DEN_W-1:0] rem_q [awbgc_pkg::DIV_LAT];
	logic [awbgc_pkg::DEN_W-1:0] den_q [awbgc_pkg::DIV_LAT];

	genvar i;
	for (i = 0; i < awbgc_pkg::DIV_LAT; i++) begin : g_st
		logic [awbgc_pkg::DIV_W-1:0] n_in, n_nx;
		logic [awbgc_pkg::DEN_W-1:0] r_in, r_nx, d_in;

		if (i == 0) begin : g_first
			assign n_in = dividend;
			assign r_in = '0;
			assign d_in = divisor;
		end else begin : g_next
			assign n_in = num_q[i-1];
			assign r_in = rem_q[i-1];
			assign d_in = den_q[i-1];
		end

		always_comb begin
			logic [awbgc_pkg::DEN_W:0]   t;
			logic [awbgc_pkg::DIV_W-1:0] n;
			logic [awbgc_pkg::DEN_W-1:0] r;
			n = n_in;
			r = r_in;
			for (int k = 0; k < awbgc_pkg::DIV_STEP; k++) begin
				t = {r, n[awbgc_pkg::DIV_W-1]};
				n = {n[awbgc_pkg::DIV_W-2:0], 1'b0};
				if (t >= {1'b0, d_in}) begin
					t    = t - {1'b0, d_in};
					n[0] = 1'b1;
				end
				r = t[awbgc_pkg::DEN_W-1:0];
			end
			n_nx = n;
			r_nx = r;
		end

		always_ff @(posedge clk) begin
			num_q[i] <= n_nx;
			rem_q[i] <= r_nx;
			den_q[i] <= d_in;
		end
	end

	assign quotient = num_q[awbgc_pkg::DIV_LAT-1];

endmodule

@@ sv/awbgc_front.sv @@
// ----------------------------------------------------------------------------
// AWB gain calc front end
// Accepts requests, forms red/green and blue/green ratios, classifies them.
// ----------------------------------------------------------------------------
module awbgc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           red_measured,
	input  logic [7:0]           green_measured,
	input  logic [7:0]           blue_measured,
	input  awbgc_pkg::cfg_t      cfg,
	input  logic                 mq_pop,
	output logic                 cls_vld,
	output awbgc_pkg::cls_t      cls
);

	logic                              acc;
	logic [awbgc_pkg::DIV_W-1:0]       rq, bq;
	logic [awbgc_pkg::DIV_LAT-1:0]     vld_q;
	logic [awbgc_pkg::DIV_LAT-1:0]     gz_q;
	logic [awbgc_pkg::MIDQ_CW-1:0]     cnt_q;
	logic                              cls_vld_s1;
	awbgc_pkg::cls_t                   cls_s1;
	logic [awbgc_pkg::RATIO_W-1:0]     rg, bg;

	assign full = (cnt_q == awbgc_pkg::MIDQ_CW'(awbgc_pkg::MIDQ_DEPTH));
	assign acc  = push && !full;

	awbgc_div u_div_rg (
		.clk      (clk),
		.dividend (awbgc_pkg::DIV_W'({red_measured, 10'b0})),
		.divisor  (awbgc_pkg::DEN_W'(green_measured)),
		.quotient (rq)
	);

	awbgc_div u_div_bg (
		.clk      (clk),
		.dividend (awbgc_pkg::DIV_W'({blue_measured, 10'b0})),
		.divisor  (awbgc_pkg::DEN_W'(green_measured)),
		.quotient (bq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[awbgc_pkg::DIV_LAT-2:0], acc};
		end
	end

	always_ff @(posedge clk) begin
		gz_q <= {gz_q[awbgc_pkg::DIV_LAT-2:0], (green_measured == 8'd0)};
	end

	assign rg = rq[awbgc_pkg::RATIO_W-1:0];
	assign bg = bq[awbgc_pkg::RATIO_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_vld_s1 <= 1'b0;
		end else begin
			cls_vld_s1 <= vld_q[awbgc_pkg::DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		cls_s1.rg         <= rg;
		cls_s1.bg         <= bg;
		cls_s1.green_zero <= gz_q[awbgc_pkg::DIV_LAT-1];
		cls_s1.bg_lt      <= bg < awbgc_pkg::RATIO_W'(cfg.bgt);
		cls_s1.rg_lt      <= rg < awbgc_pkg::RATIO_W'(cfg.rgt);
	end

	// credits cover items in flight plus items in the middle queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({acc, mq_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign cls_vld = cls_vld_s1;
	assign cls     = cls_s1;

endmodule

@@ sv/awbgc_back.sv @@
// ----------------------------------------------------------------------------
// AWB gain calc back end
// Middle queue, gain quotients, branch select, chained quotient, result queue.
// ----------------------------------------------------------------------------
`include "awb_otp_gain_calc_core_assert.svh"

module awbgc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  awbgc_pkg::cfg_t      cfg,
	input  logic                 cls_vld,
	input  awbgc_pkg::cls_t      cls,
	output logic                 mq_pop,
	output logic                 empty,
	input  logic                 pop,
	output awbgc_pkg::res_t      res
);

	typedef struct packed {
		logic                        fault;
		logic [awbgc_pkg::GG_W-1:0]  r;
		logic [awbgc_pkg::GG_W-1:0]  g;
		logic [awbgc_pkg::GG_W-1:0]  b;
		logic [1:0]                  chain;
	} chn_t;

	function automatic logic [awbgc_pkg::GAIN_W-1:0] sat(input logic [awbgc_pkg::DIV_W-1:0] v);
		logic [awbgc_pkg::GAIN_W-1:0] o;
		o = (|v[awbgc_pkg::DIV_W-1:awbgc_pkg::GAIN_W]) ? awbgc_pkg::GAIN_MAX
			: v[awbgc_pkg::GAIN_W-1:0];
		return o;
	endfunction

	// middle queue
	awbgc_pkg::cls_t                 mq_mem [awbgc_pkg::MIDQ_DEPTH];
	logic [awbgc_pkg::MIDQ_AW-1:0]   mq_wr_q, mq_rd_q;
	logic [awbgc_pkg::MIDQ_CW-1:0]   mq_cnt_q;
	awbgc_pkg::cls_t                 head;
	logic                            issue;
	logic [awbgc_pkg::OUTQ_CW-1:0]   bk_cnt_q;

	assign head   = mq_mem[mq_rd_q];
	assign issue  = (mq_cnt_q != '0) && (bk_cnt_q < awbgc_pkg::OUTQ_CW'(awbgc_pkg::OUTQ_DEPTH));
	assign mq_pop = issue;

	always_ff @(posedge clk) begin
		if (cls_vld) begin
			mq_mem[mq_wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mq_wr_q  <= '0;
			mq_rd_q  <= '0;
			mq_cnt_q <= '0;
		end else begin
			if (cls_vld) begin
				mq_wr_q <= mq_wr_q + 1'b1;
			end
			if (issue) begin
				mq_rd_q <= mq_rd_q + 1'b1;
			end
			case ({cls_vld, issue})
				2'b10:   mq_cnt_q <= mq_cnt_q + 1'b1;
				2'b01:   mq_cnt_q <= mq_cnt_q - 1'b1;
				default: mq_cnt_q <= mq_cnt_q;
			endcase
		end
	end

	// gain quotients
	logic [awbgc_pkg::DIV_W-1:0] q0, q1, q2, q3;

	awbgc_div u_div_b (
		.clk      (clk),
		.dividend (awbgc_pkg::DIV_W'({cfg.bgt, 8'b0})),
		.divisor  (head.bg),
		.quotient (q0)
	);

	awbgc_div u_div_r (
		.clk      (clk),
		.dividend (awbgc_pkg::DIV_W'({cfg.rgt, 8'b0})),
		.divisor  (head.rg),
		.quotient (q1)
	);

	awbgc_div u_div_gr (
		.clk      (clk),
		.dividend (awbgc_pkg::DIV_W'({head.rg, 8'b0})),
		.divisor  (awbgc_pkg::DEN_W'(cfg.rgt)),
		.quotient (q2)
	);

	awbgc_div u_div_gb (
		.clk      (clk),
		.dividend (awbgc_pkg::DIV_W'({head.bg, 8'b0})),
		.divisor  (awbgc_pkg::DEN_W'(cfg.bgt)),
		.quotient (q3)
	);

	logic [awbgc_pkg::DIV_LAT-1:0] sa_vld_q;
	awbgc_pkg::cls_t               sa_q [awbgc_pkg::DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sa_vld_q <= '0;
		end else begin
			sa_vld_q <= {sa_vld_q[awbgc_pkg::DIV_LAT-2:0], issue};
		end
	end

	always_ff @(posedge clk) begin
		sa_q[0] <= head;
		for (int k = 1; k < awbgc_pkg::DIV_LAT; k++) begin
			sa_q[k] <= sa_q[k-1];
		end
	end

	// branch select
	awbgc_pkg::cls_t               h;
	chn_t                          sel;
	logic [awbgc_pkg::CFG_W-1:0]   mulb;
	logic [awbgc_pkg::DEN_W-1:0]   den;
	logic [awbgc_pkg::GG_W-1:0]    gb, gr, unity_w;

	assign h       = sa_q[awbgc_pkg::DIV_LAT-1];
	assign gb      = q3[awbgc_pkg::GG_W-1:0];
	assign gr      = q2[awbgc_pkg::GG_W-1:0];
	assign unity_w = awbgc_pkg::GG_W'(awbgc_pkg::UNITY_GAIN);

	always_comb begin
		sel.fault = 1'b0;
		sel.r     = unity_w;
		sel.g     = unity_w;
		sel.b     = unity_w;
		sel.chain = awbgc_pkg::CH_NONE;
		mulb      = cfg.bgt;
		den       = h.bg;
		if (h.green_zero) begin
			sel.fault = 1'b1;
		end else if (h.bg_lt && h.rg_lt) begin
			sel.fault = (h.bg == '0) || (h.rg == '0);
			sel.b     = q0[awbgc_pkg::GG_W-1:0];
			sel.r     = q1[awbgc_pkg::GG_W-1:0];
		end else if (h.bg_lt) begin
			sel.fault = (cfg.rgt == '0) || (h.bg == '0);
			sel.g     = gr;
			sel.chain = awbgc_pkg::CH_BLUE;
		end else if (h.rg_lt) begin
			sel.fault = (cfg.bgt == '0) || (h.rg == '0);
			sel.g     = gb;
			sel.chain = awbgc_pkg::CH_RED;
			mulb      = cfg.rgt;
			den       = h.rg;
		end else if ((cfg.bgt == '0) || (cfg.rgt == '0)) begin
			sel.fault = 1'b1;
		end else if (gb > gr) begin
			sel.fault = (h.rg == '0);
			sel.g     = gb;
			sel.chain = awbgc_pkg::CH_RED;
			mulb      = cfg.rgt;
			den       = h.rg;
		end else begin
			sel.fault = (h.bg == '0);
			sel.g     = gr;
			sel.chain = awbgc_pkg::CH_BLUE;
		end
	end

	logic                          vld_s1, vld_s2;
	chn_t                          chn_s1, chn_s2;
	logic [awbgc_pkg::CFG_W-1:0]   mulb_s1;
	logic [awbgc_pkg::DEN_W-1:0]   den_s1, den_s2;
	logic [awbgc_pkg::DIV_W-1:0]   prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= sa_vld_q[awbgc_pkg::DIV_LAT-1];
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		chn_s1  <= sel;
		mulb_s1 <= mulb;
		den_s1  <= den;
		chn_s2  <= chn_s1;
		den_s2  <= den_s1;
		prod_s2 <= awbgc_pkg::DIV_W'(chn_s1.g) * awbgc_pkg::DIV_W'(mulb_s1);
	end

	// chained quotient
	logic [awbgc_pkg::DIV_W-1:0]   qc;
	logic [awbgc_pkg::DIV_LAT-1:0] sc_vld_q;
	chn_t                          sc_q [awbgc_pkg::DIV_LAT];

	awbgc_div u_div_chain (
		.clk      (clk),
		.dividend (prod_s2),
		.divisor  (den_s2),
		.quotient (qc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_vld_q <= '0;
		end else begin
			sc_vld_q <= {sc_vld_q[awbgc_pkg::DIV_LAT-2:0], vld_s2};
		end
	end

	always_ff @(posedge clk) begin
		sc_q[0] <= chn_s2;
		for (int k = 1; k < awbgc_pkg::DIV_LAT; k++) begin
			sc_q[k] <= sc_q[k-1];
		end
	end

	chn_t             c;
	awbgc_pkg::res_t  fin;

	assign c = sc_q[awbgc_pkg::DIV_LAT-1];

	always_comb begin
		fin.fault = c.fault;
		fin.green = sat(awbgc_pkg::DIV_W'(c.g));
		fin.red   = (c.chain == awbgc_pkg::CH_RED) ? sat(qc)
			: sat(awbgc_pkg::DIV_W'(c.r));
		fin.blue  = (c.chain == awbgc_pkg::CH_BLUE) ? sat(qc)
			: sat(awbgc_pkg::DIV_W'(c.b));
		if (c.fault) begin
			fin.red   = awbgc_pkg::UNITY_GAIN;
			fin.green = awbgc_pkg::UNITY_GAIN;
			fin.blue  = awbgc_pkg::UNITY_GAIN;
		end
	end

	// result queue
	awbgc_pkg::res_t                 oq_mem [awbgc_pkg::OUTQ_DEPTH];
	logic [awbgc_pkg::OUTQ_AW-1:0]   oq_wr_q, oq_rd_q;
	logic [awbgc_pkg::OUTQ_CW-1:0]   oq_cnt_q;
	logic                            oq_wr, oq_rd;

	assign oq_wr = sc_vld_q[awbgc_pkg::DIV_LAT-1];
	assign empty = (oq_cnt_q == '0);
	assign oq_rd = pop && !empty;
	assign res   = oq_mem[oq_rd_q];

	always_ff @(posedge clk) begin
		if (oq_wr) begin
			oq_mem[oq_wr_q] <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
			bk_cnt_q <= '0;
		end else begin
			if (oq_wr) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (oq_rd) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			case ({oq_wr, oq_rd})
				2'b10:   oq_cnt_q <= oq_cnt_q + 1'b1;
				2'b01:   oq_cnt_q <= oq_cnt_q - 1'b1;
				default: oq_cnt_q <= oq_cnt_q;
			endcase
			case ({issue, oq_rd})
				2'b10:   bk_cnt_q <= bk_cnt_q + 1'b1;
				2'b01:   bk_cnt_q <= bk_cnt_q - 1'b1;
				default: bk_cnt_q <= bk_cnt_q;
			endcase
		end
	end

	`AWB_ASSERT_NEVER(a_oq_ovf, oq_wr && (oq_cnt_q == awbgc_pkg::OUTQ_CW'(awbgc_pkg::OUTQ_DEPTH)))
	`AWB_ASSERT_NEVER(a_mq_ovf, cls_vld && (mq_cnt_q == awbgc_pkg::MIDQ_CW'(awbgc_pkg::MIDQ_DEPTH)))
	`AWB_ASSERT_IMPL(a_issue_credit, issue, bk_cnt_q < awbgc_pkg::OUTQ_CW'(awbgc_pkg::OUTQ_DEPTH))
	`AWB_ASSERT_IMPL(a_pop_credit, oq_rd, bk_cnt_q != '0)

endmodule

@@ sv/awb_otp_gain_calc_core.sv @@
// Throughput: one request per cycle while full is low, set by the pipelined
// dividers (4 bits/stage). A front ratio stage and a back gain stage are
// parted by a 16-entry queue; a 32-entry result queue lets results wait, and
// once both queues fill, full holds the input.
// Reset (arst_n low) empties all queues and loads the golden ratio defaults.
// ----------------------------------------------------------------------------
// AWB OTP gain calc core
// White balance gains from measured R/G/B calibration values.
// ----------------------------------------------------------------------------
module awb_otp_gain_calc_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  red_measured,
	input  logic [7:0]  green_measured,
	input  logic [7:0]  blue_measured,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] red_gain,
	output logic [15:0] green_gain,
	output logic [15:0] blue_gain,
	output logic        divide_fault,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_wdata
);

	awbgc_pkg::cfg_t  cfg_q;
	awbgc_pkg::cls_t  cls;
	awbgc_pkg::res_t  res;
	logic             cls_vld;
	logic             mq_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rgt <= awbgc_pkg::RG_TYP_RST;
			cfg_q.bgt <= awbgc_pkg::BG_TYP_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				awbgc_pkg::CFG_RG_TYP: cfg_q.rgt <= cfg_wdata;
				awbgc_pkg::CFG_BG_TYP: cfg_q.bgt <= cfg_wdata;
				default:               cfg_q     <= cfg_q;
			endcase
		end
	end

	awbgc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.red_measured   (red_measured),
		.green_measured (green_measured),
		.blue_measured  (blue_measured),
		.cfg            (cfg_q),
		.mq_pop         (mq_pop),
		.cls_vld        (cls_vld),
		.cls            (cls)
	);

	awbgc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.cls_vld (cls_vld),
		.cls     (cls),
		.mq_pop  (mq_pop),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

	assign red_gain     = res.red;
	assign green_gain   = res.green;
	assign blue_gain    = res.blue;
	assign divide_fault = res.fault;

endmodule
